// ===== src/sida_pkg.sv =====
// shared types, constants and the binary to bcd step for the decimal text converter
package sida_pkg;

    localparam int unsigned VALUE_W    = 32;
    localparam int unsigned DIGITS     = 10;
    localparam int unsigned BCD_W      = 4 * DIGITS;
    localparam int unsigned BITS_PER_S = 8;
    localparam int unsigned DAB_STAGES = VALUE_W / BITS_PER_S;
    localparam int unsigned POS_W      = 4;
    localparam int unsigned TOTAL_W    = 4;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;

    typedef struct packed {
        logic               neg;
        logic [BCD_W-1:0]   bcd;
        logic [VALUE_W-1:0] rem;
    } sida_stage_t;

    // eight double-dabble steps, most significant remaining bit first
    function automatic sida_stage_t sida_dabble(input sida_stage_t d);
        sida_stage_t r;
        r = d;
        for (int i = 0; i < BITS_PER_S; i++)
        begin
            for (int k = 0; k < DIGITS; k++)
            begin
                if (r.bcd[4*k +: 4] >= 4'd5)
                begin
                    r.bcd[4*k +: 4] = r.bcd[4*k +: 4] + 4'd3;
                end
            end
            r.bcd = {r.bcd[BCD_W-2:0], r.rem[VALUE_W-1]};
            r.rem = {r.rem[VALUE_W-2:0], 1'b0};
        end
        return r;
    endfunction

endpackage

// ===== src/sida_dabble_stage.sv =====
// one pipeline stage of the binary to bcd conversion, with valid and stall handling
module sida_dabble_stage
    import sida_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  sida_stage_t in_data,
    output logic        in_ready,
    output logic        out_valid,
    output sida_stage_t out_data,
    input  logic        out_ready
);

    logic        valid_reg;
    sida_stage_t data_reg;
    sida_stage_t data_next;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;
    assign data_next = sida_dabble(in_data);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

// ===== src/sida_serialiser.sv =====
// sends the sign and the significant digits one character per cycle
module sida_serialiser
    import sida_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  sida_stage_t        in_data,
    output logic               in_ready,
    output logic               strobe,
    output logic [7:0]         text_char,
    output logic               is_last,
    output logic [TOTAL_W-1:0] char_total
);

    logic               active_reg;
    logic               neg_pending_reg;
    logic [BCD_W-1:0]   digits_reg;
    logic [POS_W-1:0]   pos_reg;
    logic [TOTAL_W-1:0] total_reg;

    logic               strobe_reg;
    logic [7:0]         char_reg;
    logic               last_reg;
    logic [TOTAL_W-1:0] total_out_reg;

    logic               last_now;
    logic               load;
    logic [POS_W-1:0]   nd;
    logic [3:0]         cur_digit;
    logic [7:0]         char_next;

    // count of significant digits, at least one
    always_comb
    begin
        nd = POS_W'(1);
        for (int i = 0; i < DIGITS; i++)
        begin
            if (in_data.bcd[4*i +: 4] != 4'd0)
            begin
                nd = POS_W'(i + 1);
            end
        end
    end

    assign last_now  = active_reg && !neg_pending_reg && (pos_reg == '0);
    assign in_ready  = !active_reg || last_now;
    assign load      = in_valid && in_ready;
    assign cur_digit = digits_reg[{pos_reg, 2'b00} +: 4];
    assign char_next = neg_pending_reg ? CHAR_MINUS : (CHAR_ZERO + {4'd0, cur_digit});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= active_reg;
            if (load)
            begin
                active_reg <= 1'b1;
            end
            else if (last_now)
            begin
                active_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            digits_reg      <= in_data.bcd;
            neg_pending_reg <= in_data.neg;
            pos_reg         <= nd - POS_W'(1);
            total_reg       <= nd + TOTAL_W'(in_data.neg);
        end
        else if (active_reg)
        begin
            if (neg_pending_reg)
            begin
                neg_pending_reg <= 1'b0;
            end
            else
            begin
                pos_reg <= pos_reg - POS_W'(1);
            end
        end
        if (active_reg)
        begin
            char_reg      <= char_next;
            last_reg      <= last_now;
            total_out_reg <= last_now ? total_reg : '0;
        end
    end

    assign strobe     = strobe_reg;
    assign text_char  = char_reg;
    assign is_last    = last_reg;
    assign char_total = total_out_reg;

endmodule

// ===== src/signed_int_to_decimal_ascii_top.sv =====
// top level of the signed 32-bit integer to decimal ascii text converter
//
// usage
//   input: drive value and raise start; the item is taken at a rising edge where
//   start is high and busy is low. busy low means the entry register is free.
//   output: one character per cycle on text_char, marked by strobe, sign first
//   for negative values, then digits most significant first. is_last marks the
//   final character of an item and char_total (1 to 11) comes with it; it is 0
//   on every other character.
//   path: the first character passes the entry register (loaded at the
//   accepting edge), then four bcd stages of eight bits each, the
//   serialiser and the output register.
//   flow: an item occupies the single character output while its 1 to 11
//   characters go out, one per cycle; up to five items wait in the pipeline
//   while the serialiser runs and busy rises when they are all held.
//   reset: rst_n clears all valid bits and the strobe; nothing else is kept.
//   the receiver cannot stall: every strobed character must be taken.
module signed_int_to_decimal_ascii_top
    import sida_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] value,
    output logic               strobe,
    output logic [7:0]         text_char,
    output logic               is_last,
    output logic [3:0]         char_total
);

    logic        s0_valid_reg;
    sida_stage_t s0_data_reg;
    sida_stage_t s0_data_next;

    logic        vld  [DAB_STAGES+1];
    logic        rdy  [DAB_STAGES+1];
    sida_stage_t data [DAB_STAGES+1];

    logic accept;

    assign busy   = s0_valid_reg && !rdy[0];
    assign accept = start && !busy;

    always_comb
    begin
        s0_data_next.neg = value[31];
        s0_data_next.bcd = '0;
        s0_data_next.rem = value[31] ? (32'd0 - value) : value;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else if (!busy)
        begin
            s0_valid_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s0_data_reg <= s0_data_next;
        end
    end

    assign vld[0]  = s0_valid_reg;
    assign data[0] = s0_data_reg;

    for (genvar g = 0; g < DAB_STAGES; g++)
    begin : g_dab
        sida_dabble_stage u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (vld[g]),
            .in_data   (data[g]),
            .in_ready  (rdy[g]),
            .out_valid (vld[g+1]),
            .out_data  (data[g+1]),
            .out_ready (rdy[g+1])
        );
    end

    sida_serialiser u_ser (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (vld[DAB_STAGES]),
        .in_data    (data[DAB_STAGES]),
        .in_ready   (rdy[DAB_STAGES]),
        .strobe     (strobe),
        .text_char  (text_char),
        .is_last    (is_last),
        .char_total (char_total)
    );

endmodule

// ===== src/sida_checker.sv =====
// port level checks for the decimal text converter and their binding
module sida_checker
    import sida_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        strobe,
    input logic [7:0]  text_char,
    input logic        is_last,
    input logic [3:0]  char_total
);

    a_total_zero: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !is_last |-> char_total == 4'd0)
        else $error("char_total set on a character that is not last");

    a_total_range: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && is_last |-> char_total >= 4'd1 && char_total <= 4'd11)
        else $error("char_total out of range on last character");

    a_run_unbroken: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !is_last |=> strobe)
        else $error("gap inside a character run");

    a_minus_then_digit: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && text_char == CHAR_MINUS |=> strobe && text_char >= CHAR_ZERO
            && text_char <= CHAR_ZERO + 8'd9)
        else $error("sign not followed by a digit");

    a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && is_last |-> text_char != CHAR_MINUS)
        else $error("run ends on a sign");

endmodule

bind signed_int_to_decimal_ascii_top sida_checker u_sida_checker (.*);

// ===== test/signed_int_to_decimal_ascii_top_tb.sv =====
// testbench for the signed integer to decimal text converter: each character checked in order
`timescale 1ns / 1ps

module signed_int_to_decimal_ascii_top_tb
    import sida_pkg::*;
();

    localparam int unsigned QUIET_LIMIT = 2000;
    localparam int unsigned DRAIN_CYCLES = 20;
    localparam int unsigned MAX_REPORTS = 10;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic [3:0] total;
    } text_entry_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic signed [31:0] value;
    logic               strobe;
    logic [7:0]         text_char;
    logic               is_last;
    logic [3:0]         char_total;

    text_entry_t expected_chars[$];
    text_entry_t next_char;
    int unsigned items_sent;
    int unsigned chars_checked;
    int unsigned negatives_sent;
    int unsigned mismatches;
    int unsigned quiet_cycles;

    signed_int_to_decimal_ascii_top i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .value      (value),
        .strobe     (strobe),
        .text_char  (text_char),
        .is_last    (is_last),
        .char_total (char_total)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    function automatic void predict_text(input logic [31:0] v);
        logic [31:0] mag;
        logic [7:0]  digits_rev[$];
        logic [7:0]  chars[$];
        text_entry_t e;
        mag = v[31] ? (32'd0 - v) : v;
        do
        begin
            digits_rev.push_back(CHAR_ZERO + 8'(mag % 32'd10));
            mag = mag / 32'd10;
        end
        while (mag != 32'd0 && digits_rev.size() < DIGITS);
        if (v[31])
        begin
            chars.push_back(CHAR_MINUS);
        end
        for (int j = digits_rev.size() - 1; j >= 0; j--)
        begin
            chars.push_back(digits_rev[j]);
        end
        for (int k = 0; k < chars.size(); k++)
        begin
            e.ch    = chars[k];
            e.last  = (k == chars.size() - 1);
            e.total = e.last ? 4'(chars.size()) : 4'd0;
            expected_chars.push_back(e);
        end
    endfunction

    function automatic logic [31:0] random_value();
        int unsigned digit_count;
        int unsigned low;
        int unsigned high;
        logic        neg;
        logic [31:0] mag;
        if ($urandom_range(0, 4) == 0)
        begin
            return $urandom;
        end
        digit_count = $urandom_range(1, DIGITS);
        neg = 1'($urandom_range(0, 1));
        low = 1;
        for (int i = 1; i < digit_count; i++)
        begin
            low = low * 10;
        end
        if (digit_count == 1)
        begin
            low  = 0;
            high = 9;
        end
        else if (digit_count == DIGITS)
        begin
            high = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        else
        begin
            high = low * 10 - 1;
        end
        mag = $urandom_range(high, low);
        return neg ? (32'd0 - mag) : mag;
    endfunction

    // called just after a rising edge; returns at the accepting edge with start still high
    task automatic send_value(input logic [31:0] v, input bit allow_idle);
        if (allow_idle && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        start <= 1'b1;
        value <= v;
        do
        begin
            @(posedge clk);
        end
        while (busy);
        predict_text(v);
        items_sent++;
        if (v[31])
        begin
            negatives_sent++;
        end
    endtask

    task automatic test_directed();
        logic [31:0] edge_values[$];
        edge_values = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'd9, 32'd10, -32'sd10, 32'd99,
                        32'd100, -32'sd101, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001,
                        32'd1000000000, -32'sd999999999, 32'd999999999, 32'd1234567890,
                        -32'sd1234567890, 32'd5, -32'sd9, 32'hAAAA_AAAA, 32'h5555_5555,
                        32'd4000, -32'sd1000000000};
        foreach (edge_values[i])
        begin
            send_value(edge_values[i], 1'b1);
        end
    endtask

    task automatic test_random_idle(input int unsigned count);
        repeat (count)
        begin
            send_value(random_value(), 1'b1);
        end
    endtask

    task automatic test_back_to_back(input int unsigned count);
        repeat (count)
        begin
            send_value(random_value(), 1'b0);
        end
        start <= 1'b0;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && strobe)
        begin
            if (expected_chars.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                begin
                    $display("unexpected character: text_char %h is_last %b char_total %0d",
                             text_char, is_last, char_total);
                end
            end
            else
            begin
                next_char = expected_chars.pop_front();
                chars_checked++;
                if (text_char !== next_char.ch || is_last !== next_char.last ||
                    char_total !== next_char.total)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                    begin
                        $display("mismatch: expected %h/%b/%0d, actual %h/%b/%0d",
                                 next_char.ch, next_char.last, next_char.total,
                                 text_char, is_last, char_total);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || strobe)
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
                if (quiet_cycles >= QUIET_LIMIT)
                begin
                    $display("timeout with %0d characters outstanding", expected_chars.size());
                    $display("FAILURE");
                    $finish;
                end
            end
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        start          = 1'b0;
        value          = '0;
        items_sent     = 0;
        chars_checked  = 0;
        negatives_sent = 0;
        mismatches     = 0;
        quiet_cycles   = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_directed();
        test_random_idle(330);
        test_back_to_back(100);

        while (expected_chars.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("converted %0d values (%0d negative), %0d characters compared",
                 items_sent, negatives_sent, chars_checked);
        $display("edge values, random magnitudes of every length and back-to-back items, "
                 , "%0d mismatches", mismatches);
        if (mismatches == 0 && expected_chars.size() == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
